// ===== sv/gkc_pkg.sv =====
package gkc_pkg;

   // Sizing
   localparam int MAX_VERTICES = 16;
   localparam int MAX_COLORS   = 15;

   localparam int VTX_W = $clog2(MAX_VERTICES);      // vertex index
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);  // vertex count, 0..MAX_VERTICES
   localparam int COL_W = $clog2(MAX_COLORS + 1);    // stored color, 0..MAX_COLORS
   localparam int TRY_W = $clog2(MAX_COLORS + 2);    // trial color, up to MAX_COLORS+1

   // Fixed field widths
   localparam int CMD_W      = 2;
   localparam int VFIELD_W   = 4;
   localparam int NV_W       = 5;
   localparam int NC_W       = 4;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 5;

   // Commands
   localparam logic [CMD_W-1:0] CMD_EDGE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SOLVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_VERTICES = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLORS   = 4'd1;

   // Reset values of the registers
   localparam logic [NV_W-1:0] NV_RESET = 5'd16;
   localparam logic [NC_W-1:0] NC_RESET = 4'd3;

   // Microcode
   typedef enum logic [1:0] {
      UOP_FETCH,
      UOP_INIT,
      UOP_STEP,
      UOP_EMIT
   } uop_type;

   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_SOLVE,
      COND_DONE,
      COND_SLOT
   } cond_type;

   localparam int PC_W = 2;
   typedef logic [PC_W-1:0] pc_type;

   localparam pc_type PC_FETCH = 2'd0;
   localparam pc_type PC_INIT  = 2'd1;
   localparam pc_type PC_STEP  = 2'd2;
   localparam pc_type PC_EMIT  = 2'd3;

   typedef struct packed {
      uop_type  op;
      cond_type cond;
      pc_type   jump;   // taken when cond holds
      pc_type   next;   // taken otherwise
   } uword_type;

   // Datapath status seen by the sequencer
   typedef struct packed {
      logic solve_acc;
      logic done;
      logic result;
   } stat_type;

   // Control store
   function automatic uword_type ucode_rom(input pc_type pc);
      uword_type w;
      unique case (pc)
         PC_FETCH: w = '{op: UOP_FETCH, cond: COND_SOLVE,  jump: PC_INIT,  next: PC_FETCH};
         PC_INIT:  w = '{op: UOP_INIT,  cond: COND_ALWAYS, jump: PC_STEP,  next: PC_STEP};
         PC_STEP:  w = '{op: UOP_STEP,  cond: COND_DONE,   jump: PC_EMIT,  next: PC_STEP};
         PC_EMIT:  w = '{op: UOP_EMIT,  cond: COND_SLOT,   jump: PC_FETCH, next: PC_EMIT};
      endcase
      return w;
   endfunction

endpackage

// ===== sv/graph_k_coloring_backtrack_core.sv =====
// k-colorability engine for a small undirected graph.
// Request channel (req_*): one transfer per command. Add edge and clear take
// effect in the cycle of the transfer and produce no response; outside a solve
// they may be sent back to back at one per cycle. Solve runs a depth-first
// backtracking search over the stored graph, giving exactly one response transfer.
// Response channel (rsp_*): colorable bit, 1 when num_vertices vertices can be
// colored with num_colors colors.
// Steps of a solve: an init step, then one pass of the color-select unit per
// search move (each vertex placement or backtrack), one more pass to see that
// every vertex is placed (a dead end at the first vertex ends the search
// instead), then an emit step that loads the response register. req_tready
// stays low from the solve transfer until the response is loaded.
// Configuration (csr_*): index 0 num_vertices, index 1 num_colors; always
// ready, write only while the engine is idle.
// Reset: synchronous; empties the adjacency matrix, num_vertices = 16,
// num_colors = 3, no response pending.
// Stall: the response register holds the result while rsp_tready is low; a
// new edge or clear is still taken, and a following solve runs but waits
// before loading its answer until the register is free.
module graph_k_coloring_backtrack_core
   import gkc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [1:0] cmd, [5:2] vertex_a, [9:6] vertex_b
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] colorable
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   uword_type uw;
   stat_type  stat;

   logic [NV_W-1:0] nv_ff, nv_in;
   logic [NC_W-1:0] nc_ff, nc_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_col_ff, rsp_col_in;
   logic            req_accept;
   logic            slot_free;
   logic            rsp_load;

   logic [CMD_W-1:0]    cmd;
   logic [VFIELD_W-1:0] vertex_a;
   logic [VFIELD_W-1:0] vertex_b;

   assign cmd      = req_tdata[CMD_W-1:0];
   assign vertex_a = req_tdata[CMD_W +: VFIELD_W];
   assign vertex_b = req_tdata[CMD_W + VFIELD_W +: VFIELD_W];

   assign req_tready = (uw.op == UOP_FETCH);
   assign req_accept = req_tvalid && req_tready;

   // Configuration registers
   assign csr_ready = 1'b1;
   always_comb begin
      nv_in = nv_ff;
      nc_in = nc_ff;
      if (csr_valid) begin
         priority case (csr_index)
            CSR_NUM_VERTICES: nv_in = csr_data[NV_W-1:0];
            CSR_NUM_COLORS:   nc_in = csr_data[NC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Response register
   assign slot_free    = !rsp_valid_ff || rsp_tready;
   assign rsp_load     = (uw.op == UOP_EMIT) && slot_free;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   assign rsp_col_in   = rsp_load ? stat.result : rsp_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff        <= NV_RESET;
         nc_ff        <= NC_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         nv_ff        <= nv_in;
         nc_ff        <= nc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_col_ff <= rsp_col_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-1){1'b0}}, rsp_col_ff};

   gkc_useq u_useq (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .slot_free (slot_free),
      .uw        (uw)
   );

   gkc_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .uw           (uw),
      .req_accept   (req_accept),
      .cmd          (cmd),
      .vertex_a     (vertex_a),
      .vertex_b     (vertex_b),
      .num_vertices (nv_ff),
      .num_colors   (nc_ff),
      .stat         (stat)
   );

`ifndef SYNTH
   // A solve transfer closes the request channel for the next cycle
   a_solve_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_accept && cmd == CMD_SOLVE) |=> !req_tready)
      else $error("request channel open right after a solve transfer");

   // A response only appears out of the emit step
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(uw.op == UOP_EMIT))
      else $error("response raised outside the emit step");

   // Emit with a free slot always loads a response
   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (uw.op == UOP_EMIT && slot_free) |=> rsp_tvalid)
      else $error("emit step did not load the response register");
`endif

endmodule

// ===== sv/gkc_useq.sv =====
module gkc_useq
   import gkc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  stat_type  stat,
   input  logic      slot_free,
   output uword_type uw
);

   pc_type pc_ff, pc_in;
   logic   cond_true;

   assign uw = ucode_rom(pc_ff);

   // Branch condition select
   always_comb begin
      unique case (uw.cond)
         COND_ALWAYS: cond_true = 1'b1;
         COND_SOLVE:  cond_true = stat.solve_acc;
         COND_DONE:   cond_true = stat.done;
         COND_SLOT:   cond_true = slot_free;
      endcase
      pc_in = cond_true ? uw.jump : uw.next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_FETCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== sv/gkc_dpath.sv =====
module gkc_dpath
   import gkc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  uword_type           uw,
   input  logic                req_accept,
   input  logic [CMD_W-1:0]    cmd,
   input  logic [VFIELD_W-1:0] vertex_a,
   input  logic [VFIELD_W-1:0] vertex_b,
   input  logic [NV_W-1:0]     num_vertices,
   input  logic [NC_W-1:0]     num_colors,
   output stat_type            stat
);

   // Adjacency rows, per-vertex colors, prefix max of colors below each vertex
   logic [MAX_VERTICES-1:0] adj_ff   [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] adj_in   [MAX_VERTICES];
   logic [COL_W-1:0]        color_ff [MAX_VERTICES];
   logic [COL_W-1:0]        color_in [MAX_VERTICES];
   logic [COL_W-1:0]        pm_ff    [MAX_VERTICES];
   logic [COL_W-1:0]        pm_in    [MAX_VERTICES];
   logic [CNT_W-1:0]        cv_ff, cv_in;
   logic [TRY_W-1:0]        tc_ff, tc_in;
   logic                    res_ff, res_in;

   logic [CNT_W-1:0]    n_sat;
   logic [COL_W-1:0]    k_sat;
   logic [VTX_W-1:0]    vi, vp, va, vb;
   logic                at_end;
   logic                edge_ok;
   logic [MAX_VERTICES-1:0] row;
   logic [MAX_COLORS:0] used;
   logic [COL_W-1:0]    pm_v;
   logic [TRY_W-1:0]    limit;
   logic                found;
   logic [COL_W-1:0]    pick;
   logic [COL_W-1:0]    pm_new;

   // Saturated configuration
   assign n_sat = (int'(num_vertices) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                     : CNT_W'(num_vertices);
   assign k_sat = (int'(num_colors) > MAX_COLORS) ? COL_W'(MAX_COLORS)
                                                 : COL_W'(num_colors);

   assign vi      = cv_ff[VTX_W-1:0];
   assign vp      = vi - VTX_W'(1);
   assign at_end  = (cv_ff >= n_sat);
   assign va      = VTX_W'(vertex_a);
   assign vb      = VTX_W'(vertex_b);
   assign edge_ok = (int'(vertex_a) < MAX_VERTICES) && (int'(vertex_b) < MAX_VERTICES);
   assign row     = adj_ff[vi];

   // Colors held by neighbors of the current vertex (self-loop excluded)
   always_comb begin
      used = '0;
      for (int j = 0; j < MAX_VERTICES; j++) begin
         if (row[j] && (CNT_W'(j) < n_sat) && (VTX_W'(j) != vi)) begin
            used[color_ff[j]] = 1'b1;
         end
      end
   end

   // Trial window: from trial color up to one above the highest color below, capped at k
   always_comb begin
      pm_v  = (vi == '0) ? '0 : pm_ff[vi];
      limit = TRY_W'(pm_v) + TRY_W'(1);
      if (limit > TRY_W'(k_sat)) begin
         limit = TRY_W'(k_sat);
      end
   end

   // Lowest free color in the window
   always_comb begin
      found = 1'b0;
      pick  = '0;
      for (int c = MAX_COLORS; c >= 1; c--) begin
         if (!used[c] && (TRY_W'(c) >= tc_ff) && (TRY_W'(c) <= limit)) begin
            found = 1'b1;
            pick  = COL_W'(c);
         end
      end
      pm_new = (pick > pm_v) ? pick : pm_v;
   end

   // Next state per micro-op
   always_comb begin
      adj_in   = adj_ff;
      color_in = color_ff;
      pm_in    = pm_ff;
      cv_in    = cv_ff;
      tc_in    = tc_ff;
      res_in   = res_ff;
      unique case (uw.op)
         UOP_FETCH: begin
            if (req_accept) begin
               priority case (cmd)
                  CMD_EDGE: begin
                     if (edge_ok) begin
                        adj_in[va][vb] = 1'b1;
                        adj_in[vb][va] = 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     for (int i = 0; i < MAX_VERTICES; i++) begin
                        adj_in[i] = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         UOP_INIT: begin
            for (int i = 0; i < MAX_VERTICES; i++) begin
               color_in[i] = '0;
            end
            cv_in = '0;
            tc_in = TRY_W'(1);
         end
         UOP_STEP: begin
            if (at_end) begin
               res_in = 1'b1;
            end else if (found) begin
               color_in[vi] = pick;
               if (vi != VTX_W'(MAX_VERTICES - 1)) begin
                  pm_in[vi + VTX_W'(1)] = pm_new;
               end
               cv_in = cv_ff + CNT_W'(1);
               tc_in = TRY_W'(1);
            end else begin
               // dead end: undo, step back and advance the previous vertex
               color_in[vi] = '0;
               if (vi == '0) begin
                  res_in = 1'b0;
               end else begin
                  cv_in        = cv_ff - CNT_W'(1);
                  tc_in        = TRY_W'(color_ff[vp]) + TRY_W'(1);
                  color_in[vp] = '0;
               end
            end
         end
         UOP_EMIT: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         adj_ff <= '{default: '0};
      end else begin
         adj_ff <= adj_in;
      end
      color_ff <= color_in;
      pm_ff    <= pm_in;
      cv_ff    <= cv_in;
      tc_ff    <= tc_in;
      res_ff   <= res_in;
   end

   assign stat.solve_acc = (uw.op == UOP_FETCH) && req_accept && (cmd == CMD_SOLVE);
   assign stat.done      = (uw.op == UOP_STEP) && (at_end || (!found && vi == '0));
   assign stat.result    = res_ff;

endmodule
